[sv/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Item structs, register indexes, frame geometry and the operand bundle of
// the shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // Address and register geometry.
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int FRAME_SHIFT = 12;

  // One memory word holds this many used/free marks.
  localparam int WORD_BITS   = 32;
  localparam int WORD_SHIFT  = 5;
  localparam int BIT_W       = 5;

  // Default size of the frame map.
  localparam int DEF_MAX_FRAMES = 1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDR   = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } cfg_reg_t;

  // Request codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Input item.
  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] frame_addr;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic              fail;
  } out_item_t;

  // Operands for the shared add/subtract unit.
  typedef struct packed {
    logic              sub;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } addsub_op_t;

endpackage

`default_nettype wire

[sv/page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator: first-fit page frame allocator
// Keeps one used/free mark per 4 KiB frame and serves allocate and free items.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                           Handshake
//  -------  ------------------------------  -------------------------------
//  input    start, busy, in_item            taken when start & !busy
//  result   out_valid, out_item             one-cycle strobe, never stalled
//  config   cfg_we, cfg_index, cfg_wdata    written when cfg_we is high
//
//  An allocate steps through a read state and a check state for each 32-frame
//  word scanned, then an add state when it finds a frame; it fails when the
//  frames run out. A free passes through subtract, check and write states,
//  and ends after the check when out of range. The result strobe falls in the first
//  cycle with busy low. After reset a clearing pass writes every word to free,
//  with busy high. Nothing can stall.
//
`default_nettype none

module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int NWORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);

  typedef enum logic [7:0] {
    S_CLR       = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_ALLOC_RD  = 8'b0000_0100,
    S_ALLOC_CHK = 8'b0000_1000,
    S_ALLOC_ADD = 8'b0001_0000,
    S_FREE_SUB  = 8'b0010_0000,
    S_FREE_CHK  = 8'b0100_0000,
    S_FREE_WR   = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    base_r;
  logic [COUNT_W-1:0]   count_r;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [WADDR_W-1:0]   word_r, word_nxt;
  logic [WADDR_W-1:0]   clr_r, clr_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [CNT_W-1:0]     left_r, left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic [ADDR_W-1:0]    fc32, max32, n32, left32, idx32, widx32, frame32;
  logic [CNT_W-1:0]     active_n;
  logic [WORD_BITS-1:0] valid_mask, masked, bit_mask;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;

  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_addr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  addsub_op_t           as_op;
  logic [ADDR_W-1:0]    as_result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDR:   base_r  <= cfg_wdata;
        REG_FRAME_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame count, limited to the size of the map.
  assign fc32     = ADDR_W'(count_r);
  assign max32    = ADDR_W'(MAX_FRAMES);
  assign n32      = (fc32 > max32) ? max32 : fc32;
  assign active_n = n32[CNT_W-1:0];

  // Frame index of a free, taken from the offset held in addr_r.
  assign idx32  = addr_r >> FRAME_SHIFT;
  assign widx32 = idx32 >> WORD_SHIFT;

  // Frame index of the found free mark.
  assign frame32 = (ADDR_W'(word_r) << WORD_SHIFT) | ADDR_W'(bit_r);

  // Marks beyond the last managed frame count as used.
  assign left32     = ADDR_W'(left_r);
  assign valid_mask = (left32 >= ADDR_W'(WORD_BITS)) ? '1
                    : ((WORD_BITS'(1) << left32[BIT_W-1:0]) - WORD_BITS'(1));
  assign masked     = mem_rdata | ~valid_mask;
  assign bit_mask   = WORD_BITS'(1) << bit_r;

  // Lowest free mark in the word just read.
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        hit     = 1'b1;
        hit_bit = BIT_W'(i);
      end
    end
  end

  pfa_addsub u_addsub (
    .op     (as_op),
    .result (as_result)
  );

  pfa_mark_ram #(
    .DEPTH (NWORDS),
    .AW    (WADDR_W)
  ) u_marks (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    word_nxt      = word_r;
    clr_nxt       = clr_r;
    bit_nxt       = bit_r;
    left_nxt      = left_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_addr      = word_r;
    mem_wdata     = mem_rdata;
    as_op.sub     = 1'b0;
    as_op.a       = base_r;
    as_op.b       = frame32 << FRAME_SHIFT;

    unique case (state_r)
      // Clear every word to free after reset.
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + WADDR_W'(1);
        if (clr_r == WADDR_W'(NWORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Wait for an item.
      S_IDLE: begin
        if (start) begin
          addr_nxt = in_item.frame_addr;
          word_nxt = '0;
          left_nxt = active_n;
          if (in_item.req_type == REQ_FREE) begin
            state_nxt = S_FREE_SUB;
          end else begin
            state_nxt = S_ALLOC_RD;
          end
        end
      end

      // Read the next word of marks, or fail when none are left.
      S_ALLOC_RD: begin
        if (left_r == '0) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.alloc_addr = '0;
          out_item_nxt.fail       = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          state_nxt = S_ALLOC_CHK;
        end
      end

      // Claim the lowest free mark, or move on to the next word.
      S_ALLOC_CHK: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (WORD_BITS'(1) << hit_bit);
          bit_nxt   = hit_bit;
          state_nxt = S_ALLOC_ADD;
        end else if (left32 <= ADDR_W'(WORD_BITS)) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.alloc_addr = '0;
          out_item_nxt.fail       = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          word_nxt  = word_r + WADDR_W'(1);
          left_nxt  = CNT_W'(left32 - ADDR_W'(WORD_BITS));
          state_nxt = S_ALLOC_RD;
        end
      end

      // Address of the claimed frame: base plus index times the frame size.
      S_ALLOC_ADD: begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.alloc_addr = as_result;
        out_item_nxt.fail       = 1'b0;
        state_nxt               = S_IDLE;
      end

      // Offset of the freed address from the base.
      S_FREE_SUB: begin
        as_op.sub = 1'b1;
        as_op.a   = addr_r;
        as_op.b   = base_r;
        addr_nxt  = as_result;
        state_nxt = S_FREE_CHK;
      end

      // Range check, then read the word that holds the mark.
      S_FREE_CHK: begin
        if (idx32 < n32) begin
          mem_addr  = widx32[WADDR_W-1:0];
          word_nxt  = widx32[WADDR_W-1:0];
          bit_nxt   = idx32[BIT_W-1:0];
          state_nxt = S_FREE_WR;
        end else begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.alloc_addr = '0;
          out_item_nxt.fail       = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      // Clear the mark and report success.
      S_FREE_WR: begin
        mem_we                  = 1'b1;
        mem_wdata               = mem_rdata & ~bit_mask;
        out_valid_nxt           = 1'b1;
        out_item_nxt.alloc_addr = '0;
        out_item_nxt.fail       = 1'b0;
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    left_r     <= left_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[sv/pfa_addsub.sv]
// ----------------------------------------------------------------------------
// pfa_addsub: shared 32-bit add/subtract unit
// Forms base plus frame offset on allocate and address minus base on free.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_addsub
  import pfa_pkg::*;
(
  input  addsub_op_t        op,
  output logic [ADDR_W-1:0] result
);

  // Two's complement subtract by inverting b and adding one; wraps modulo 2^32.
  assign result = op.a + (op.sub ? ~op.b : op.b) + ADDR_W'(op.sub);

endmodule

`default_nettype wire

[sv/pfa_mark_ram.sv]
// ----------------------------------------------------------------------------
// pfa_mark_ram: word-wide store of the used/free marks
// One port: a write and a registered read of the old word at one address each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_mark_ram
  import pfa_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_FRAMES / WORD_BITS,
  parameter int AW     = 5
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write when we is high, and read the old word with the data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
